@@ sv/rrts_pkg.sv @@
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int NUM_CORES   = 4;
    localparam int QUEUE_DEPTH = 256;
    localparam int TASK_BITS   = 8;

    localparam int Q_IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CORE_IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    localparam int OP_W       = 2;
    localparam int CORE_W     = 2;
    localparam int TID_W      = 8;
    localparam int NEXT_W     = 8;
    localparam int QUANTUM_W  = 16;
    localparam int NUM_QREGS  = 4;
    localparam int QREG_IDX_W = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

    typedef logic [TASK_BITS-1:0] task_t;
    typedef logic [QUANTUM_W-1:0] quantum_t;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_TICK    = 2'd1,
        OP_EXIT    = 2'd2
    } op_t;

    typedef struct packed {
        logic  shift;
        logic  load;
        task_t data;
    } q_cmd_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic [NEXT_W-1:0] next_task;
        logic              idle;
        logic              overflowed;
    } res_t;

endpackage

@@ sv/rrts_if.sv @@
`timescale 1ns / 1ps

interface rrts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [1:0] core;
    logic [7:0] task_id;

    modport source (output valid, output op, output core, output task_id, input ready);
    modport sink   (input valid, input op, input core, input task_id, output ready);
endinterface

interface rrts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] next_task;
    logic       idle;
    logic       overflowed;

    modport source (output valid, output next_task, output idle, output overflowed,
                    input ready);
    modport sink   (input valid, input next_task, input idle, input overflowed,
                    output ready);
endinterface

@@ sv/rrts_cell.sv @@
`timescale 1ns / 1ps

module rrts_cell (
    input  logic                clk,
    input  logic                shift,
    input  logic                load,
    input  rrts_pkg::task_t     load_data,
    input  rrts_pkg::task_t     from_next,
    output rrts_pkg::task_t     data
);

    rrts_pkg::task_t data_reg;
    rrts_pkg::task_t data_next;

    // load wins over shift: on a rotate the tail cell takes the new task
    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ sv/rrts_queue.sv @@
`timescale 1ns / 1ps

module rrts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  rrts_pkg::q_cmd_t    cmd,
    output rrts_pkg::task_t     head,
    output rrts_pkg::q_stat_t   stat
);

    localparam int DEPTH = rrts_pkg::QUEUE_DEPTH;

    rrts_pkg::task_t                cell_data [DEPTH];
    logic [rrts_pkg::CNT_W-1:0]     count_reg;
    logic [rrts_pkg::CNT_W-1:0]     count_next;
    logic [rrts_pkg::CNT_W-1:0]     count_m1;
    logic [rrts_pkg::Q_IDX_W-1:0]   load_pos;

    // cell 0 is the head; a pop moves every entry one cell toward it
    assign count_m1 = count_reg - 1'b1;
    assign load_pos = cmd.shift ? count_m1[rrts_pkg::Q_IDX_W-1:0]
                                : count_reg[rrts_pkg::Q_IDX_W-1:0];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            rrts_pkg::task_t nxt;
            if (i == DEPTH - 1)
            begin : g_last
                assign nxt = cell_data[i];
            end
            else
            begin : g_mid
                assign nxt = cell_data[i+1];
            end

            rrts_cell u_cell (
                .clk       (clk),
                .shift     (cmd.shift),
                .load      (cmd.load && (load_pos == rrts_pkg::Q_IDX_W'(i))),
                .load_data (cmd.data),
                .from_next (nxt),
                .data      (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load && !cmd.shift)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.shift && !cmd.load)
        begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head       = cell_data[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == rrts_pkg::CNT_W'(DEPTH));
    assign stat.count = count_reg;

endmodule

@@ sv/round_robin_task_scheduler.sv @@
`timescale 1ns / 1ps

// Round-robin scheduler for up to four cores sharing one ready queue.
// in_ch carries one beat per item: op 0 enqueues task_id, op 1 is a timer
// tick on core, op 2 means the core's current task blocked or exited.
// Enqueue beats give no result; each tick or block/exit beat on a valid core
// gives one out_ch beat (next_task, idle, sticky overflowed). Op 3 and cores
// past the last one are dropped silently.
// The APB port holds the four slice lengths at byte addresses 0, 4, 8, 12;
// write them only while the block is idle.
// Throughput: one item per cycle while in_ch.ready is high. Results are
// written to the result buffer on acceptance, behind any waiting beat. The
// ready queue is a row of 256 cells with the head in cell 0; a pop shifts
// every cell one place in the same cycle, and a push loads the cell at the
// fill count, so each item is one queue access plus one counter update.
// Results sit in a two-beat buffer; in_ch.ready drops only while both beats
// wait, so a stalled receiver holds the input back without losing anything.
// Reset: queue empty, all cores idle, overflow flag clear, slices at 10.

module round_robin_task_scheduler (
    input  logic                clk,
    input  logic                rst_n,
    rrts_in_if.sink             in_ch,
    rrts_out_if.source          out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NC = rrts_pkg::NUM_CORES;

    rrts_pkg::quantum_t quantum_reg [rrts_pkg::NUM_QREGS];

    rrts_pkg::quantum_t ticks_reg [NC];
    rrts_pkg::task_t    run_reg   [NC];
    logic [NC-1:0]      busy_reg;
    logic               ovf_reg;

    rrts_pkg::q_cmd_t   q_cmd;
    rrts_pkg::task_t    q_head;
    rrts_pkg::q_stat_t  q_stat;

    rrts_pkg::res_t     buf_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         ocount_reg;
    logic [1:0]         ocount_next;

    logic                               acc;
    logic                               core_ok;
    logic                               sched;
    logic                               enq;
    logic [rrts_pkg::CORE_IDX_W-1:0]    cidx;
    rrts_pkg::task_t                    tid;
    rrts_pkg::quantum_t                 q_sel;
    rrts_pkg::quantum_t                 ticks_cur;
    rrts_pkg::quantum_t                 ticks_dec;
    rrts_pkg::quantum_t                 ticks_next;
    rrts_pkg::task_t                    run_next;
    logic                               busy_next;
    logic                               ovf_next;
    rrts_pkg::res_t                     res;
    logic                               out_pop;
    logic                               cfg_wr;

    // ---------------------------------------------------------------
    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = rrts_pkg::PDATA_W'(quantum_reg[paddr[3:2]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < rrts_pkg::NUM_QREGS; r++)
            begin
                quantum_reg[r] <= rrts_pkg::QUANTUM_RESET;
            end
        end
        else if (cfg_wr)
        begin
            quantum_reg[paddr[3:2]] <= pwdata[rrts_pkg::QUANTUM_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // item decode
    assign in_ch.ready = (ocount_reg != 2'd2);
    assign acc         = in_ch.valid && in_ch.ready;
    assign core_ok     = (int'(in_ch.core) < NC);
    assign cidx        = in_ch.core[rrts_pkg::CORE_IDX_W-1:0];
    assign tid         = rrts_pkg::task_t'(in_ch.task_id);
    assign enq         = acc && (in_ch.op == rrts_pkg::OP_ENQUEUE);

    always_comb
    begin
        sched = 1'b0;
        case (rrts_pkg::op_t'(in_ch.op))
            rrts_pkg::OP_TICK,
            rrts_pkg::OP_EXIT:  sched = acc && core_ok;
            default:            sched = 1'b0;
        endcase
    end

    assign q_sel     = quantum_reg[in_ch.core];
    assign ticks_cur = ticks_reg[cidx];
    assign ticks_dec = ticks_cur - 1'b1;

    always_comb
    begin
        q_cmd.shift = 1'b0;
        q_cmd.load  = 1'b0;
        q_cmd.data  = tid;
        ticks_next  = ticks_cur;
        run_next    = run_reg[cidx];
        busy_next   = busy_reg[cidx];
        ovf_next    = ovf_reg;

        if (enq)
        begin
            if (q_stat.full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                q_cmd.load = 1'b1;
            end
        end
        else if (sched)
        begin
            if (!busy_reg[cidx] || (in_ch.op == rrts_pkg::OP_EXIT))
            begin
                if (!q_stat.empty)
                begin
                    q_cmd.shift = 1'b1;
                    run_next    = q_head;
                    busy_next   = 1'b1;
                    ticks_next  = q_sel;
                end
                else if (busy_reg[cidx])
                begin
                    busy_next = 1'b0;
                    run_next  = '0;
                end
            end
            else
            begin
                ticks_next = ticks_dec;
                if (ticks_dec == '0)
                begin
                    // slice over: reload; unless queue empty, head out, task to tail
                    if (!q_stat.empty)
                    begin
                        q_cmd.shift = 1'b1;
                        q_cmd.load  = 1'b1;
                        q_cmd.data  = run_reg[cidx];
                        run_next    = q_head;
                    end
                    ticks_next = q_sel;
                end
            end
        end
    end

    rrts_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .head  (q_head),
        .stat  (q_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                ticks_reg[c] <= '0;
                run_reg[c]   <= '0;
            end
            busy_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            ovf_reg <= ovf_next;
            if (sched)
            begin
                ticks_reg[cidx] <= ticks_next;
                run_reg[cidx]   <= run_next;
                busy_reg[cidx]  <= busy_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // result buffer
    assign res.next_task  = busy_next ? rrts_pkg::NEXT_W'(run_next) : '0;
    assign res.idle       = !busy_next;
    assign res.overflowed = ovf_reg;

    assign out_pop = out_ch.valid && out_ch.ready;

    always_comb
    begin
        ocount_next = ocount_reg;
        if (sched && !out_pop)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (out_pop && !sched)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            ocount_reg <= '0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (sched)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sched)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

    assign out_ch.valid      = (ocount_reg != '0);
    assign out_ch.next_task  = buf_reg[rd_ptr_reg].next_task;
    assign out_ch.idle       = buf_reg[rd_ptr_reg].idle;
    assign out_ch.overflowed = buf_reg[rd_ptr_reg].overflowed;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH))
        else $error("ready queue fill count past its depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (enq && !q_stat.full) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("enqueue into a non-full queue did not add an entry");

    a_sched_result: assert property (@(posedge clk) disable iff (!rst_n)
        sched |=> out_ch.valid)
        else $error("schedule beat produced no result beat");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.idle) |-> (out_ch.next_task == '0))
        else $error("idle result carries a task id");
`endif

endmodule
